>>> rtl/idt_pkg.sv
// Package: table sizing, request and result beat types, request and status codes.
package idt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;
  localparam logic [1:0] REQ_DUMP   = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_ZEROKEY  = 3'd5;
  localparam logic [2:0] ST_USED     = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         slot_index;
    logic signed [31:0] slot_value;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic [IDX_W-1:0]   addr;
    logic signed [31:0] data;
  } tbl_wr_t;

endpackage

>>> rtl/idt_table.sv
// Slot memory with per-slot valid bits; an invalid slot reads as zero.
module idt_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [idt_pkg::IDX_W-1:0] rd_addr,
  output logic signed [31:0]        rd_data,
  input  idt_pkg::tbl_wr_t          wr
);

  logic signed [31:0]             mem [idt_pkg::TABLE_DEPTH];
  logic [idt_pkg::TABLE_DEPTH-1:0] vld;

  // valid bits: clear all at reset, set on store, drop on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= !wr.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.clr) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, masked by the valid bit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

>>> rtl/id_table_insert_remove_search_top.sv
// Top level: identifier table with add, remove, search and dump requests.
//
// The table holds TABLE_DEPTH identifier slots in one memory with a single
// registered read port; zero marks a free slot and every slot is free right
// after reset (per-slot valid bits clear at once, so there is no clearing
// pass). Each request walks the slots in order, one slot per cycle through
// that read port unless the output holds it. Add stops at the first free
// slot and search at the first match; remove and dump walk every slot. An
// add, remove or search with key zero answers status zero-key-rejected.
// Dump sends one beat per slot and holds the walk while rsp_stall is
// high. A new request is taken once the previous one has handed its last
// beat to the output register, which may still wait on rsp_stall.
module id_table_insert_remove_search_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  idt_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output idt_pkg::rsp_t  rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                      state, state_next;
  idt_pkg::req_t             item;
  logic [idt_pkg::CNT_W-1:0] rd_cnt;
  logic [idt_pkg::IDX_W-1:0] cmp_idx;
  logic                      cmp_vld;
  logic                      hit;

  logic signed [31:0]        rd_data;
  logic                      rd_en;
  idt_pkg::tbl_wr_t          tbl_wr;

  logic          accept, zk, out_free, cmp_last, match, free;
  logic          term, need_out, fire, adv, push, done;
  idt_pkg::rsp_t rsp_next;

  idt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt[idt_pkg::IDX_W-1:0]),
    .rd_data (rd_data),
    .wr      (tbl_wr)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign zk        = (item.req_type != idt_pkg::REQ_DUMP) && (item.key == 32'sd0);
  assign cmp_last  = (cmp_idx == idt_pkg::IDX_W'(idt_pkg::TABLE_DEPTH - 1));
  assign match     = (rd_data == item.key);
  assign free      = (rd_data == 32'sd0);

  // per-request decision at the compare stage
  always_comb begin
    term            = 1'b0;
    need_out        = 1'b0;
    tbl_wr.en       = 1'b0;
    tbl_wr.clr      = 1'b0;
    tbl_wr.addr     = cmp_idx;
    tbl_wr.data     = item.key;
    rsp_next.status     = idt_pkg::ST_NOTFOUND;
    rsp_next.slot_index = '0;
    rsp_next.slot_value = '0;
    rsp_next.last       = 1'b1;
    unique case (item.req_type)
      idt_pkg::REQ_ADD: begin
        term            = free || cmp_last;
        rsp_next.status = free ? idt_pkg::ST_ADDED : idt_pkg::ST_FULL;
        if (free) begin
          rsp_next.slot_index = 5'(cmp_idx);
        end
        tbl_wr.en = free;
      end
      idt_pkg::REQ_REMOVE: begin
        term            = cmp_last;
        rsp_next.status = (hit || match) ? idt_pkg::ST_REMOVED : idt_pkg::ST_NOTFOUND;
        tbl_wr.en       = match;
        tbl_wr.clr      = 1'b1;
      end
      idt_pkg::REQ_SEARCH: begin
        term            = match || cmp_last;
        rsp_next.status = match ? idt_pkg::ST_FOUND : idt_pkg::ST_NOTFOUND;
        if (match) begin
          rsp_next.slot_index = 5'(cmp_idx);
        end
      end
      idt_pkg::REQ_DUMP: begin
        term                = cmp_last;
        rsp_next.status     = free ? idt_pkg::ST_EMPTY : idt_pkg::ST_USED;
        rsp_next.slot_index = 5'(cmp_idx);
        rsp_next.slot_value = rd_data;
        rsp_next.last       = cmp_last;
      end
      default: begin
        term = 1'b1;
      end
    endcase
    need_out = (item.req_type == idt_pkg::REQ_DUMP) || term;
    // zero key: answer without touching the table
    if (zk) begin
      rsp_next.status     = idt_pkg::ST_ZEROKEY;
      rsp_next.slot_index = '0;
      rsp_next.slot_value = '0;
      rsp_next.last       = 1'b1;
    end
    fire = cmp_vld && (!need_out || out_free);
    // writes only commit when the compared slot retires
    tbl_wr.en = tbl_wr.en && fire;
  end

  // advance the read pointer only when the compare stage drains
  assign adv   = !cmp_vld || fire;
  assign rd_en = (state == S_SCAN) && !zk && (rd_cnt < idt_pkg::CNT_W'(idt_pkg::TABLE_DEPTH))
                 && adv && !(fire && term);
  assign push  = (fire && need_out) || ((state == S_SCAN) && zk && out_free);
  assign done  = (fire && term) || ((state == S_SCAN) && zk && out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cmp_vld <= 1'b0;
      rd_cnt  <= '0;
      hit     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_cnt <= '0;
        hit    <= 1'b0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      // drop the in-flight read when the walk ends early
      if (rd_en) begin
        cmp_vld <= 1'b1;
      end else if (fire) begin
        cmp_vld <= 1'b0;
      end
      if (fire && match && (item.req_type == idt_pkg::REQ_REMOVE)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (rd_en) begin
      cmp_idx <= rd_cnt[idt_pkg::IDX_W-1:0];
    end
  end

  // output register: hold while stalled, load on push
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= rsp_next;
    end
  end

  a_idle_no_cmp : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!cmp_vld && !rd_en))
    else $error("compare stage busy while idle");

  a_wr_needs_cmp : assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (cmp_vld && (state == S_SCAN)))
    else $error("table write outside a compare");

  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    (push && rsp_next.last) |=> (state == S_IDLE))
    else $error("walk continues after last beat");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed over a waiting beat");

endmodule

>>> tb/sv/tb_id_table_insert_remove_search_top.sv
// Testbench: identifier table add, remove, search and dump, checked beat by beat.
module tb_id_table_insert_remove_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DRAIN_CYCLES = idt_pkg::TABLE_DEPTH + 8;
  localparam int  HOLD_CYCLES  = 250;
  localparam int  RAND_PER_PH  = 21;
  localparam int  MAX_REPORTS  = 20;
  localparam real LIMIT_NS     = 2_000_000.0;

  // Scoreboard: keeps its own image of the table, predicts the beats of each
  // accepted request and checks result beats in order.
  class key_table_scoreboard;
    logic [31:0]   slot_img [idt_pkg::TABLE_DEPTH];
    idt_pkg::rsp_t pending_rsp [$];
    int            errors;
    int            beats;
    int            n_req [4];
    int            n_status [8];

    function new();
      foreach (slot_img[i]) slot_img[i] = '0;
      errors = 0;
      beats  = 0;
      foreach (n_req[i]) n_req[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (slot_img[i]) if (slot_img[i] != '0) n++;
      return n;
    endfunction

    function void push_beat(logic [2:0] st, int idx, logic [31:0] val, logic lst);
      idt_pkg::rsp_t r;
      r.status     = st;
      r.slot_index = idx[4:0];
      r.slot_value = val;
      r.last       = lst;
      pending_rsp.push_back(r);
    endfunction

    function void note_request(idt_pkg::req_t r);
      logic hit;
      int   found;
      hit   = 1'b0;
      found = -1;
      n_req[r.req_type]++;
      if (r.req_type == idt_pkg::REQ_DUMP) begin
        for (int i = 0; i < idt_pkg::TABLE_DEPTH; i++)
          push_beat(slot_img[i] != '0 ? idt_pkg::ST_USED : idt_pkg::ST_EMPTY, i,
                    slot_img[i], i == idt_pkg::TABLE_DEPTH - 1);
      end else if (r.key == '0) begin
        push_beat(idt_pkg::ST_ZEROKEY, 0, '0, 1'b1);
      end else if (r.req_type == idt_pkg::REQ_ADD) begin
        for (int i = 0; i < idt_pkg::TABLE_DEPTH; i++)
          if (found < 0 && slot_img[i] == '0) found = i;
        if (found >= 0) begin
          slot_img[found] = r.key;
          push_beat(idt_pkg::ST_ADDED, found, '0, 1'b1);
        end else begin
          push_beat(idt_pkg::ST_FULL, 0, '0, 1'b1);
        end
      end else if (r.req_type == idt_pkg::REQ_REMOVE) begin
        // clear every copy, answer once
        for (int i = 0; i < idt_pkg::TABLE_DEPTH; i++)
          if (slot_img[i] == r.key) begin
            slot_img[i] = '0;
            hit = 1'b1;
          end
        push_beat(hit ? idt_pkg::ST_REMOVED : idt_pkg::ST_NOTFOUND, 0, '0, 1'b1);
      end else begin
        for (int i = 0; i < idt_pkg::TABLE_DEPTH; i++)
          if (found < 0 && slot_img[i] == r.key) found = i;
        if (found >= 0) push_beat(idt_pkg::ST_FOUND, found, '0, 1'b1);
        else            push_beat(idt_pkg::ST_NOTFOUND, 0, '0, 1'b1);
      end
    endfunction

    function void check_response(idt_pkg::rsp_t a);
      idt_pkg::rsp_t e;
      beats++;
      n_status[a.status]++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result beat st=%0d idx=%0d val=%h last=%0b",
                   $time, a.status, a.slot_index, a.slot_value, a.last);
        return;
      end
      e = pending_rsp.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch exp st=%0d idx=%0d val=%h last=%0b,",
                   $time, e.status, e.slot_index, e.slot_value, e.last,
                   " got st=%0d idx=%0d val=%h last=%0b",
                   a.status, a.slot_index, a.slot_value, a.last);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  idt_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  idt_pkg::rsp_t rsp;

  key_table_scoreboard sb;

  int          send_idle_pct;
  int          stall_pct;
  int          hold_left;
  bit          hold_start;
  logic [31:0] key_pool [8];

  id_table_insert_remove_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // Drive the receiver stall at each falling edge. A requested hold-off
  // keeps stall high until its countdown in hold_left runs out, so the
  // block backs up and has to stall its request side.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sample result beats on the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Offer one request beat; idle first at random, then hold the payload
  // until it is taken. The beat is noted at the edge that accepts it.
  task automatic push_req(input idt_pkg::req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] k);
    idt_pkg::req_t r;
    r.req_type = op;
    r.key      = k;
    push_req(r);
  endtask

  // Hold the sender until every predicted beat has come back; drop valid
  // first so the last beat is not offered again.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Mostly keys from a small pool so adds, removes and searches collide;
  // some zero keys and some fully random ones to toggle every bit.
  function automatic logic [31:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 5)  return '0;
    if (p < 75) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic idt_pkg::req_t rand_req();
    idt_pkg::req_t r;
    int            p;
    p = $urandom_range(99);
    if (p < 40)      r.req_type = idt_pkg::REQ_ADD;
    else if (p < 65) r.req_type = idt_pkg::REQ_REMOVE;
    else if (p < 90) r.req_type = idt_pkg::REQ_SEARCH;
    else             r.req_type = idt_pkg::REQ_DUMP;
    r.key = pick_key();
    return r;
  endfunction

  initial begin
    int send_pct_tab [4];
    int stall_pct_tab [4];
    send_pct_tab  = '{0, 74, 0, 11};
    stall_pct_tab = '{0, 0, 74, 11};

    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    rsp_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    hold_start    = 1'b0;
    sb            = new();

    key_pool[0] = 32'h0000_0001;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom | 32'h1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes of the key, duplicates, zero key, dump, removal of
    // all copies, and reuse of the lowest freed slot.
    send(idt_pkg::REQ_ADD,    32'h0000_0001);
    send(idt_pkg::REQ_ADD,    32'h7FFF_FFFF);
    send(idt_pkg::REQ_ADD,    32'h8000_0000);
    send(idt_pkg::REQ_ADD,    32'hFFFF_FFFF);
    send(idt_pkg::REQ_ADD,    32'h0000_0001);
    send(idt_pkg::REQ_SEARCH, 32'h0000_0001);
    send(idt_pkg::REQ_SEARCH, 32'hFFFF_FFFF);
    send(idt_pkg::REQ_SEARCH, 32'h0000_0005);
    send(idt_pkg::REQ_ADD,    32'h0000_0000);
    send(idt_pkg::REQ_REMOVE, 32'h0000_0000);
    send(idt_pkg::REQ_SEARCH, 32'h0000_0000);
    send(idt_pkg::REQ_DUMP,   32'hA5A5_5A5A);
    send(idt_pkg::REQ_REMOVE, 32'h0000_0001);
    send(idt_pkg::REQ_SEARCH, 32'h0000_0001);
    send(idt_pkg::REQ_REMOVE, 32'h0000_0001);
    send(idt_pkg::REQ_ADD,    32'h0000_0002);
    send(idt_pkg::REQ_DUMP,   32'h0000_0000);

    // Random phases, one per idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct_tab[ph];
      stall_pct     = stall_pct_tab[ph];
      if (ph == 0) begin
        // fill the table, then overflow it twice
        while (sb.used_slots() < idt_pkg::TABLE_DEPTH)
          send(idt_pkg::REQ_ADD, $urandom | 32'h1);
        send(idt_pkg::REQ_ADD, key_pool[$urandom_range(7)]);
        send(idt_pkg::REQ_ADD, $urandom | 32'h1);
        send(idt_pkg::REQ_DUMP, $urandom);
      end
      for (int i = 0; i < RAND_PER_PH; i++) begin
        if (ph == 0 && i == 4) hold_start = 1'b1;
        if (ph == 1 && i == 12) wait_for_results();
        push_req(rand_req());
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    stall_pct = 0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d add, %0d remove, %0d search and %0d dump requests,",
             sb.n_req[idt_pkg::REQ_ADD], sb.n_req[idt_pkg::REQ_REMOVE],
             sb.n_req[idt_pkg::REQ_SEARCH], sb.n_req[idt_pkg::REQ_DUMP],
             " %0d result beats.", sb.beats);
    $display("Table-full answers: %0d, zero-key rejects: %0d, mismatches: %0d.",
             sb.n_status[idt_pkg::ST_FULL], sb.n_status[idt_pkg::ST_ZEROKEY],
             sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/idt_pkg.sv
rtl/idt_table.sv
rtl/id_table_insert_remove_search_top.sv
tb/sv/tb_id_table_insert_remove_search_top.sv
